>>> sv/iir3_pkg.sv
// ---------------------------------------------------------------------------
// iir3_pkg: shared types and constants for the third-order IIR filter
// Sample, coefficient and accumulator formats, register codes, handshake
// payload structs and the scaled feed-forward product.
// ---------------------------------------------------------------------------
package iir3_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 16;
    localparam int Y_W            = 28;  // output history, Q20.8
    localparam int ACC_W          = 48;  // exact sum at 22 fraction bits
    localparam int BX_SHIFT       = 8;   // align b*x (14 frac) with a*y (22 frac)
    localparam int ACC_FRAC_SHIFT = 14;  // accumulator -> Q20.8
    localparam int Y_FRAC_SHIFT   = 8;   // Q20.8 -> integer
    localparam int NUM_REGS       = 7;
    localparam int NUM_B          = 4;   // b0..b3 are registers, a1..a3 follow
    localparam int REG_IDX_W      = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [Y_W-1:0]      y_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_B3 = 3'd3,
        REG_A1 = 3'd4,
        REG_A2 = 3'd5,
        REG_A3 = 3'd6
    } reg_idx_t;

    localparam coef_t COEF_RESET [NUM_REGS] = '{
        16'sd1599, 16'sd7055, 16'sd7055, 16'sd1599,
        -16'sd9781, 16'sd3142, -16'sd295
    };

    typedef struct packed {
        sample_t sample_in;
        logic    last_of_block;
    } smp_item_t;

    typedef struct packed {
        sample_t sample_out;
        logic    saturated;
    } res_item_t;

    typedef struct packed {
        logic adv;    // product stage retires into the result register
        logic clear;  // retiring sample ends a block
    } cell_ctrl_t;

    // b*x scaled to 22 fraction bits
    function automatic acc_t scale_bx(coef_t b, sample_t x);
        logic signed [COEF_W+SAMPLE_W-1:0] p;
        p = b * x;
        return ACC_W'(p) <<< BX_SHIFT;
    endfunction

endpackage

>>> sv/third_order_iir_filter_top.sv
// ---------------------------------------------------------------------------
// Path: stage one registers the sample, which moves into the result register
// when stage one advances; the result is offered from that register.
// Throughput: one sample per cycle; every tap cell multiplies its held input
// and output in parallel, and the feedback through the adder row and the
// quantizer is combinational. Input stalls only behind a stalled result.
// Reset: coefficients load their default values, all history clears and
// both pipeline stages empty. No clearing pass; ready right after reset.
// ---------------------------------------------------------------------------
// third_order_iir_filter_top: third-order IIR filter, direct-form tap chain
// Stage one registers the sample and b0*x, stage two sums the taps of all
// cells and quantizes, and each cell hands its history to its neighbor.
// ---------------------------------------------------------------------------
module third_order_iir_filter_top
    import iir3_pkg::*;
#(
    parameter int TAPS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 smp_valid,
    output logic                 smp_stall,
    input  smp_item_t            smp,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_item_t            res,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  coef_t                cfg_data
);

    coef_t      coef_reg [NUM_REGS];
    logic       p1_valid_reg;
    logic       p1_valid_next;
    logic       p1_last_reg;
    acc_t       pb0_reg;
    sample_t    x0_reg;
    logic       res_valid_reg;
    logic       res_valid_next;
    res_item_t  res_reg;
    logic       load;
    logic       p1_adv;
    cell_ctrl_t ctrl;
    sample_t    x_chain [0:TAPS-1];
    y_t         y_chain [0:TAPS-1];
    acc_t       s_chain [1:TAPS];
    acc_t       acc;
    y_t         y;
    sample_t    q_sample;
    logic       q_sat;

    // coefficient registers; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coef_reg[i] <= COEF_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index) inside
                REG_B0, REG_B1, REG_B2, REG_B3, REG_A1, REG_A2, REG_A3:
                    coef_reg[cfg_index] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign load      = smp_valid && !smp_stall;
    assign p1_adv    = p1_valid_reg && (!res_valid_reg || !res_stall);
    assign smp_stall = p1_valid_reg && !p1_adv;

    assign ctrl.adv   = p1_adv;
    assign ctrl.clear = p1_last_reg;

    always_comb
    begin
        p1_valid_next = p1_valid_reg;
        if (load)
        begin
            p1_valid_next = 1'b1;
        end
        else if (p1_adv)
        begin
            p1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (p1_adv)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg  <= p1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pb0_reg     <= scale_bx(coef_reg[REG_B0], smp.sample_in);
            x0_reg      <= smp.sample_in;
            p1_last_reg <= smp.last_of_block;
        end
        if (p1_adv)
        begin
            res_reg.sample_out <= q_sample;
            res_reg.saturated  <= q_sat;
        end
    end

    // chain of tap cells; the top cell sees an empty partial sum
    assign s_chain[TAPS] = '0;
    assign x_chain[0]    = x0_reg;
    assign y_chain[0]    = y;

    for (genvar k = 1; k < TAPS; k++)
    begin : g_cell
        coef_t b_k;
        coef_t a_k;

        if (k < NUM_B)
        begin : g_coef
            assign b_k = coef_reg[k];
            assign a_k = coef_reg[k + NUM_B - 1];
        end
        else
        begin : g_zero
            assign b_k = '0;
            assign a_k = '0;
        end

        iir3_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .coef_b (b_k),
            .coef_a (a_k),
            .x_in   (x_chain[k-1]),
            .y_in   (y_chain[k-1]),
            .s_in   (s_chain[k+1]),
            .x_out  (x_chain[k]),
            .y_out  (y_chain[k]),
            .s_out  (s_chain[k])
        );
    end

    assign acc = pb0_reg + s_chain[1];

    iir3_quant u_quant (
        .acc       (acc),
        .y         (y),
        .sample    (q_sample),
        .saturated (q_sat)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> sv/iir3_cell.sv
// ---------------------------------------------------------------------------
// iir3_cell: one tap of the direct-form history chain
// Holds one delayed input and one delayed output, adds b*x - a*y of them to
// the partial sum of the next cell, and shifts its history down the row
// when a sample retires, or clears it when that sample ends a block.
// ---------------------------------------------------------------------------
module iir3_cell
    import iir3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  coef_t      coef_b,
    input  coef_t      coef_a,
    input  sample_t    x_in,
    input  y_t         y_in,
    input  acc_t       s_in,
    output sample_t    x_out,
    output y_t         y_out,
    output acc_t       s_out
);

    sample_t x_reg;
    sample_t x_next;
    y_t      y_reg;
    y_t      y_next;
    acc_t    tap;
    logic signed [COEF_W+Y_W-1:0] ay;

    always_comb
    begin
        ay    = coef_a * y_reg;
        tap   = scale_bx(coef_b, x_reg) - ACC_W'(ay);
        s_out = s_in + tap;
        if (ctrl.clear)
        begin
            x_next = '0;
            y_next = '0;
        end
        else
        begin
            x_next = x_in;
            y_next = y_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else if (ctrl.adv)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

>>> sv/iir3_quant.sv
// ---------------------------------------------------------------------------
// iir3_quant: output quantizer
// Truncates the accumulator toward zero to Q20.8 and saturates it, then
// truncates to an integer sample and saturates to 16 bits with a flag.
// ---------------------------------------------------------------------------
module iir3_quant
    import iir3_pkg::*;
(
    input  acc_t    acc,
    output y_t      y,
    output sample_t sample,
    output logic    saturated
);

    localparam int YW_W = ACC_W - ACC_FRAC_SHIFT;
    localparam int YI_W = Y_W - Y_FRAC_SHIFT;

    acc_t                   acc_adj;
    logic signed [YW_W-1:0] yw;
    logic                   y_pos_ovf;
    logic                   y_neg_ovf;
    y_t                     y_adj;
    logic signed [YI_W-1:0] yi;
    logic                   s_pos_ovf;
    logic                   s_neg_ovf;

    always_comb
    begin
        // bias negatives so the arithmetic shift rounds toward zero
        acc_adj = acc + {{(ACC_W-ACC_FRAC_SHIFT){1'b0}}, {ACC_FRAC_SHIFT{acc[ACC_W-1]}}};
        yw      = acc_adj[ACC_W-1:ACC_FRAC_SHIFT];

        y_pos_ovf = !yw[YW_W-1] && (|yw[YW_W-2:Y_W-1]);
        y_neg_ovf = yw[YW_W-1] && !(&yw[YW_W-2:Y_W-1]);
        if (y_pos_ovf)
        begin
            y = {1'b0, {(Y_W-1){1'b1}}};
        end
        else if (y_neg_ovf)
        begin
            y = {1'b1, {(Y_W-1){1'b0}}};
        end
        else
        begin
            y = yw[Y_W-1:0];
        end

        y_adj = y + {{(Y_W-Y_FRAC_SHIFT){1'b0}}, {Y_FRAC_SHIFT{y[Y_W-1]}}};
        yi    = y_adj[Y_W-1:Y_FRAC_SHIFT];

        s_pos_ovf = !yi[YI_W-1] && (|yi[YI_W-2:SAMPLE_W-1]);
        s_neg_ovf = yi[YI_W-1] && !(&yi[YI_W-2:SAMPLE_W-1]);
        if (s_pos_ovf)
        begin
            sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (s_neg_ovf)
        begin
            sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            sample = yi[SAMPLE_W-1:0];
        end
        saturated = s_pos_ovf || s_neg_ovf;
    end

endmodule

>>> sv/iir3_checker.sv
// ---------------------------------------------------------------------------
// iir3_checker: port-level checks for the IIR filter
// Watches both channels of the top level; attached by a bind below.
// ---------------------------------------------------------------------------
module iir3_checker
    import iir3_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      smp_valid,
    input logic      smp_stall,
    input smp_item_t smp,
    input logic      res_valid,
    input logic      res_stall,
    input res_item_t res
);

    // the result register is empty while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // a held result keeps its value
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    // input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        smp_stall |-> res_valid && res_stall)
        else $error("input stalled without output backpressure");

    // a transfer reaches the result register when the output is not held
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (smp_valid && !smp_stall) ##1 !res_stall |=> res_valid)
        else $error("result missing after input transfer");

    // a stalled sample stays offered and unchanged
    a_smp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && smp_stall |=> smp_valid && $stable(smp))
        else $error("stalled sample changed");

endmodule

bind third_order_iir_filter_top iir3_checker u_iir3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .smp       (smp),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
